// ===== sv/rgba_tf_pkg.sv =====
// package: shared types, constants and operation codes for the transfer function block
`default_nettype none
package rgba_tf_pkg;
  localparam int MAX_POINTS_DEF = 64;

  typedef enum logic [3:0] {
    FN_ADD_BOTH  = 4'd0,
    FN_ADD_COL   = 4'd1,
    FN_ADD_OP    = 4'd2,
    FN_REM_BOTH  = 4'd3,
    FN_REM_COL   = 4'd4,
    FN_REM_OP    = 4'd5,
    FN_CLR_BOTH  = 4'd6,
    FN_CLR_COL   = 4'd7,
    FN_CLR_OP    = 4'd8,
    FN_LOOKUP    = 4'd9
  } func_t;

  // table sequencer operations
  localparam logic [1:0] TBL_PUT    = 2'd0;
  localparam logic [1:0] TBL_REMOVE = 2'd1;
  localparam logic [1:0] TBL_CLEAR  = 2'd2;
  localparam logic [1:0] TBL_LOOKUP = 2'd3;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [24:0] num;   // magnitude of numerator
    logic [16:0] den;   // positive denominator
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [24:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== sv/rgba_tf_ram.sv =====
// generic single port ram with registered read
`default_nettype none
module rgba_tf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== sv/rgba_tf_div.sv =====
// restoring serial divider, one quotient bit per cycle
`default_nettype none
module rgba_tf_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  rgba_tf_pkg::div_req_t req,
  output rgba_tf_pkg::div_rsp_t rsp
);
  logic [24:0] quo;
  logic [17:0] rem;
  logic [16:0] den;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [17:0] trial;

  assign trial = {rem[16:0], quo[24]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= 5'd0;
      end else if (busy) begin
        if (!trial[17]) begin
          rem <= trial;
          quo <= {quo[23:0], 1'b1};
        end else begin
          rem <= {rem[16:0], quo[24]};
          quo <= {quo[23:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd24) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done, quo};
endmodule
`default_nettype wire

// ===== sv/rgba_tf_table.sv =====
// one sorted breakpoint table with its sequencer: put, remove, clear, lookup
`default_nettype none
module rgba_tf_table #(
  parameter int MAX_POINTS = rgba_tf_pkg::MAX_POINTS_DEF,
  parameter int NCH = 3
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [1:0]         op,     // sequencer operation
  input  wire logic               chk,    // only check for room, then wait
  input  wire logic               go,     // commit after check
  input  wire logic               veto,   // other table has no room, drop the put
  input  wire logic signed [15:0] key,
  input  wire logic [8*NCH-1:0]   val,
  output logic                    done,   // pulses when finished
  output logic                    full,   // valid with chk done: new key and full
  output logic [8*NCH-1:0]        res
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = 16 + 8 * NCH;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_SRCH  = 11'b00000000010,
    S_SWAIT = 11'b00000000100,
    S_DEC   = 11'b00000001000,
    S_HOLD  = 11'b00000010000,
    S_SHR   = 11'b00000100000,
    S_SHL   = 11'b00001000000,
    S_PREV  = 11'b00010000000,
    S_PWAIT = 11'b00100000000,
    S_DIV   = 11'b01000000000,
    S_DWAIT = 11'b10000000000
  } st_t;

  st_t st;
  logic [CW-1:0] count, pos, idx;
  logic [1:0]    opr;
  logic          rd_phase;
  logic [DW-1:0] hit, lo;
  logic          found;
  logic [$clog2(NCH+1)-1:0] ch;

  logic          we;
  logic [AW-1:0] addr;
  logic [DW-1:0] wdata, rdata;

  rgba_tf_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic signed [15:0] rkey, lkey;
  assign rkey = rdata[DW-1 -: 16];
  assign lkey = lo[DW-1 -: 16];

  // interpolation per channel
  rgba_tf_pkg::div_req_t dreq;
  rgba_tf_pkg::div_rsp_t drsp;
  rgba_tf_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [7:0]         va, vb;
  logic signed [16:0] dx;
  logic signed [8:0]  dv;
  logic signed [25:0] prod;
  logic               neg;
  logic [7:0]         qs;
  assign va   = lo[8*ch +: 8];
  assign vb   = hit[8*ch +: 8];
  assign dx   = 17'(key) - 17'(lkey);
  assign dv   = $signed({1'b0, vb}) - $signed({1'b0, va});
  assign prod = dx * dv;
  assign neg  = prod[25];
  assign qs   = neg ? 8'(va - drsp.quo[7:0]) : 8'(va + drsp.quo[7:0]);

  logic [16:0] dkr;

  always_comb begin
    dreq.start = (st == S_DIV);
    dreq.num   = neg ? 25'(-prod) : 25'(prod);
    dreq.den   = dkr;
  end

  always_comb begin
    we    = 1'b0;
    addr  = idx[AW-1:0];
    wdata = rdata;
    unique case (st)
      S_SHR: begin
        // write entry idx from entry idx-1 read last cycle, or new point
        we    = rd_phase;
        wdata = (idx == pos) ? {key, val} : rdata;
        addr  = rd_phase ? idx[AW-1:0] : AW'(idx - CW'(1));
      end
      S_SHL: begin
        we   = rd_phase;
        addr = rd_phase ? idx[AW-1:0] : AW'(idx + CW'(1));
      end
      S_HOLD: begin
        we    = (go || !chk) && found && !veto && opr == rgba_tf_pkg::TBL_PUT;
        wdata = {key, val};
        addr  = pos[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (st)
        S_IDLE: if (start) begin
          opr      <= op;
          res      <= '0;
          full     <= 1'b0;
          found    <= 1'b0;
          idx      <= '0;
          rd_phase <= 1'b0;
          if (op == rgba_tf_pkg::TBL_CLEAR) begin
            count <= '0;
            done  <= 1'b1;
          end else if (count == '0) begin
            pos <= '0;
            if (op == rgba_tf_pkg::TBL_PUT && chk) st <= S_HOLD;
            else if (op == rgba_tf_pkg::TBL_PUT) st <= S_SHR;
            else done <= 1'b1;
            if (op == rgba_tf_pkg::TBL_PUT && chk) done <= 1'b1;
          end else begin
            st <= S_SWAIT;
          end
        end
        S_SWAIT: st <= S_SRCH; // read latency
        S_SRCH: begin
          // linear scan for first key >= key
          if (rkey >= key) begin
            pos   <= idx;
            found <= (rkey == key);
            hit   <= rdata;
            st    <= S_DEC;
          end else if (idx == count - CW'(1)) begin
            pos <= count;
            hit <= rdata;
            st  <= S_DEC;
          end else begin
            idx <= idx + CW'(1);
            st  <= S_SWAIT;
          end
        end
        S_DEC: begin
          unique case (opr)
            rgba_tf_pkg::TBL_LOOKUP: begin
              if (found || pos == '0) begin
                res <= hit[8*NCH-1:0]; done <= 1'b1; st <= S_IDLE;
              end else if (pos == count) begin
                res <= hit[8*NCH-1:0]; done <= 1'b1; st <= S_IDLE;
              end else begin
                idx <= pos - CW'(1); st <= S_PREV;
              end
            end
            rgba_tf_pkg::TBL_REMOVE: begin
              if (found) begin
                idx <= pos; rd_phase <= 1'b0; st <= S_SHL;
                if (pos == count - CW'(1)) begin
                  count <= count - CW'(1); done <= 1'b1; st <= S_IDLE;
                end
              end else begin
                done <= 1'b1; st <= S_IDLE;
              end
            end
            default: begin
              full <= !found && count == CW'(MAX_POINTS);
              if (chk) begin
                done <= 1'b1; st <= S_HOLD;
              end else begin
                st <= S_HOLD;
              end
            end
          endcase
        end
        S_HOLD: if (go || !chk) begin
          // commit a put
          if (full || veto) begin
            done <= !chk; st <= S_IDLE;
          end else if (found) begin
            done <= 1'b1; st <= S_IDLE;
          end else begin
            idx <= count; rd_phase <= 1'b0; st <= S_SHR;
          end
        end else if (start) begin
          st <= S_IDLE; // aborted by the caller
        end
        S_SHR: begin
          if (idx == pos) begin
            if (!rd_phase) rd_phase <= 1'b1;
            else begin
              count <= count + CW'(1); done <= 1'b1; st <= S_IDLE;
            end
          end else if (!rd_phase) rd_phase <= 1'b1;
          else begin
            rd_phase <= 1'b0; idx <= idx - CW'(1);
          end
        end
        S_SHL: begin
          if (!rd_phase) rd_phase <= 1'b1;
          else if (idx == count - CW'(2)) begin
            count <= count - CW'(1); done <= 1'b1; st <= S_IDLE;
          end else begin
            rd_phase <= 1'b0; idx <= idx + CW'(1);
          end
        end
        S_PREV: st <= S_PWAIT;
        S_PWAIT: begin
          lo  <= rdata;
          ch  <= '0;
          st  <= S_DIV;
        end
        S_DIV: begin
          // rdata still holds previous entry; hit holds upper
          st <= S_DWAIT;
        end
        S_DWAIT: if (drsp.done) begin
          res[8*ch +: 8] <= qs;
          if (ch == ($clog2(NCH+1))'(NCH - 1)) begin
            done <= 1'b1; st <= S_IDLE;
          end else begin
            ch <= ch + 1'b1; st <= S_DIV;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // denominator kept as the upper key minus the lower key
  always_ff @(posedge clk) begin
    if (st == S_PWAIT) begin
      dkr <= 17'($signed(hit[DW-1 -: 16])) - 17'($signed(rdata[DW-1 -: 16]));
    end
  end
endmodule
`default_nettype wire

// ===== sv/rgba_transfer_function_lookup.sv =====
// top level: rgba transfer function lookup over two sorted breakpoint tables
`default_nettype none
// rate: one word at a time. a put or remove scans the sorted table entry by
// entry, then shifts entries where needed through the single ram port. a
// lookup scans, then, if the key lies between two points, runs its table's
// own serial divider once per channel. both tables work in parallel; the
// result word is held in an output register until taken. add both first
// checks both tables for room, then commits both or neither and finishes
// once both commits are done.
module rgba_transfer_function_lookup #(
  parameter int MAX_POINTS = rgba_tf_pkg::MAX_POINTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  func,
  input  wire logic signed [15:0] key,
  input  wire logic [7:0]  red_in,
  input  wire logic [7:0]  green_in,
  input  wire logic [7:0]  blue_in,
  input  wire logic [7:0]  opacity_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       red_out,
  output logic [7:0]       green_out,
  output logic [7:0]       blue_out,
  output logic [7:0]       opacity_out,
  output logic             status
);
  logic busy, c_start, o_start, c_done, o_done, c_full, o_full, go, both;
  logic c_pend, o_pend, fin;
  logic [1:0] c_op, o_op;
  logic [3:0] fn;
  logic [23:0] c_res;
  logic [7:0]  o_res;

  assign in_stall = busy || out_valid;
  wire accept = in_valid && !in_stall;

  always_comb begin
    c_op = rgba_tf_pkg::TBL_PUT; o_op = rgba_tf_pkg::TBL_PUT;
    c_start = 1'b0; o_start = 1'b0;
    unique case (func)
      rgba_tf_pkg::FN_ADD_BOTH: begin c_start = accept; o_start = accept; end
      rgba_tf_pkg::FN_ADD_COL:  c_start = accept;
      rgba_tf_pkg::FN_ADD_OP:   o_start = accept;
      rgba_tf_pkg::FN_REM_BOTH: begin
        c_op = rgba_tf_pkg::TBL_REMOVE; o_op = rgba_tf_pkg::TBL_REMOVE;
        c_start = accept; o_start = accept;
      end
      rgba_tf_pkg::FN_REM_COL:  begin c_op = rgba_tf_pkg::TBL_REMOVE; c_start = accept; end
      rgba_tf_pkg::FN_REM_OP:   begin o_op = rgba_tf_pkg::TBL_REMOVE; o_start = accept; end
      rgba_tf_pkg::FN_CLR_BOTH: begin
        c_op = rgba_tf_pkg::TBL_CLEAR; o_op = rgba_tf_pkg::TBL_CLEAR;
        c_start = accept; o_start = accept;
      end
      rgba_tf_pkg::FN_CLR_COL:  begin c_op = rgba_tf_pkg::TBL_CLEAR; c_start = accept; end
      rgba_tf_pkg::FN_CLR_OP:   begin o_op = rgba_tf_pkg::TBL_CLEAR; o_start = accept; end
      rgba_tf_pkg::FN_LOOKUP:   begin
        c_op = rgba_tf_pkg::TBL_LOOKUP; o_op = rgba_tf_pkg::TBL_LOOKUP;
        c_start = accept; o_start = accept;
      end
      default: ;
    endcase
  end

  logic signed [15:0] k_q;
  logic [23:0] rgb_q;
  logic [7:0]  op_q;
  logic        chk_q;

  // during the commit of add both each table drops its put when the other is full
  rgba_tf_table #(.MAX_POINTS(MAX_POINTS), .NCH(3)) u_col (
    .clk(clk), .rst(rst), .start(c_start), .op(c_op),
    .chk(accept ? (func == rgba_tf_pkg::FN_ADD_BOTH) : chk_q), .go(go),
    .veto(both && o_full),
    .key(accept ? key : k_q), .val(accept ? {red_in, green_in, blue_in} : rgb_q),
    .done(c_done), .full(c_full), .res(c_res)
  );
  rgba_tf_table #(.MAX_POINTS(MAX_POINTS), .NCH(1)) u_op (
    .clk(clk), .rst(rst), .start(o_start), .op(o_op),
    .chk(accept ? (func == rgba_tf_pkg::FN_ADD_BOTH) : chk_q), .go(go),
    .veto(both && c_full),
    .key(accept ? key : k_q), .val(accept ? opacity_in : op_q),
    .done(o_done), .full(o_full), .res(o_res)
  );

  logic committing;
  assign go  = both && !c_pend && !o_pend && !committing;
  // every started table has reported done
  assign fin = (c_pend ? c_done : 1'b1) && (o_pend ? o_done : 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; out_valid <= 1'b0; c_pend <= 1'b0; o_pend <= 1'b0;
      both <= 1'b0; committing <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept) begin
        k_q <= key; rgb_q <= {red_in, green_in, blue_in}; op_q <= opacity_in;
        fn  <= func;
        chk_q <= (func == rgba_tf_pkg::FN_ADD_BOTH);
        both  <= (func == rgba_tf_pkg::FN_ADD_BOTH);
        c_pend <= c_start; o_pend <= o_start;
        committing <= 1'b0;
        busy <= c_start || o_start;
        if (!c_start && !o_start) begin
          out_valid <= 1'b1;
          red_out <= '0; green_out <= '0; blue_out <= '0; opacity_out <= '0;
          status <= 1'b0;
        end
      end else if (busy) begin
        if (go) begin
          // both checks finished; commit both tables or reject the word
          both <= 1'b0;
          if (c_full || o_full) begin
            busy <= 1'b0; out_valid <= 1'b1;
            red_out <= '0; green_out <= '0; blue_out <= '0; opacity_out <= '0;
            status <= 1'b1;
          end else begin
            committing <= 1'b1; c_pend <= 1'b1; o_pend <= 1'b1;
          end
        end else if (fin) begin
          c_pend <= 1'b0; o_pend <= 1'b0;
          if (!both) begin
            committing <= 1'b0; busy <= 1'b0; out_valid <= 1'b1;
            if (fn == rgba_tf_pkg::FN_LOOKUP) begin
              red_out <= c_res[23:16]; green_out <= c_res[15:8]; blue_out <= c_res[7:0];
              opacity_out <= o_res;
            end else begin
              red_out <= '0; green_out <= '0; blue_out <= '0; opacity_out <= '0;
            end
            status <= ((fn == rgba_tf_pkg::FN_ADD_COL) && c_full) ||
                      ((fn == rgba_tf_pkg::FN_ADD_OP) && o_full);
          end
        end else begin
          if (c_done) c_pend <= 1'b0;
          if (o_done) o_pend <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire
